/* hw/rtl/palindrome_min_insertions_assert.svh */
// assertion macros for the palindrome insertion counter
// used by the top level only, no other dependencies
`ifndef PALINDROME_MIN_INSERTIONS_ASSERT_SVH
`define PALINDROME_MIN_INSERTIONS_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PMI_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pmi check failed: same-cycle implication");

// antecedent implies consequent in the following cycle
`define PMI_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pmi check failed: next-cycle implication");

`endif

/* hw/rtl/pmi_pkg.sv */
`timescale 1ns / 1ps
// shared constants, job descriptor and back-end state type
// no dependencies
package pmi_pkg;

   localparam int MAX_LEN     = 1024;
   localparam int ADDR_W      = $clog2(MAX_LEN);
   localparam int CNT_W       = $clog2(MAX_LEN + 1);
   localparam int CHAR_W      = 8;
   localparam int COST_W      = 10;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COST_W-1:0] COST_CAP = {COST_W{1'b1}};

   typedef struct packed {
      logic [CNT_W-1:0] len;
      logic             overflow;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_FETCH,
      BK_LOAD,
      BK_CELL,
      BK_DONE
   } back_state_type;

endpackage

/* hw/rtl/palindrome_min_insertions.sv */
`timescale 1ns / 1ps
// palindrome_min_insertions: counts the fewest characters to insert so that a
// string becomes a palindrome. characters stream in one per cycle while
// req_tready is high (tlast marks the final one) into a 1024-byte buffer;
// extra characters are dropped and flagged. after the last character the
// interval table is swept row by row, one cell per cycle through a single
// read port on the row banks, and the result appears once the sweep ends.
// input is held off during that sweep; once the result sits in the output
// register the next string may load. no clearing pass after reset.
// depends on pmi_pkg, pmi_front, pmi_queue, pmi_back and the assertion header
`include "palindrome_min_insertions_assert.svh"
module palindrome_min_insertions (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pmi_pkg::REQ_DATA_W-1:0]      req_tdata,   // [7:0] ch
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pmi_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // [9:0] min_insertions, zero pad
   output logic                                rsp_tuser    // [0] too_long
);
   import pmi_pkg::*;

   logic              q_push, q_pop, q_full, q_empty;
   job_type           push_job, pop_job;
   logic              job_done;
   logic [ADDR_W-1:0] text_addr;
   logic [CHAR_W-1:0] text_data;
   logic [COST_W-1:0] rsp_cost;

   pmi_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_ch    (req_tdata[CHAR_W-1:0]),
      .in_last  (req_tlast),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_job    (push_job),
      .job_done (job_done),
      .rd_addr  (text_addr),
      .rd_data  (text_data)
   );

   pmi_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .empty    (q_empty)
   );

   pmi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_job     (pop_job),
      .q_pop     (q_pop),
      .text_addr (text_addr),
      .text_data (text_data),
      .job_done  (job_done),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_cost  (rsp_cost),
      .out_flag  (rsp_tuser)
   );

   assign rsp_tdata = RSP_DATA_W'(rsp_cost);

   `PMI_ASSERT_NXT(a_block_after_last, clock, reset, q_push, !req_tready)
   `PMI_ASSERT_IMP(a_no_push_when_full, clock, reset, q_push, !q_full)
   `PMI_ASSERT_IMP(a_queue_drained_on_result, clock, reset, $rose(rsp_tvalid), q_empty)

endmodule

/* hw/rtl/pmi_front.sv */
`timescale 1ns / 1ps
// front end: takes characters from the stream into the text buffer
// and hands a job to the queue on the last one; depends on pmi_pkg
module pmi_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [pmi_pkg::CHAR_W-1:0]     in_ch,
   input  logic                           in_last,
   input  logic                           q_full,
   output logic                           q_push,
   output pmi_pkg::job_type               q_job,
   input  logic                           job_done,
   input  logic [pmi_pkg::ADDR_W-1:0]     rd_addr,
   output logic [pmi_pkg::CHAR_W-1:0]     rd_data
);
   import pmi_pkg::*;

   logic [CHAR_W-1:0] text_store_ff [MAX_LEN];
   logic [CHAR_W-1:0] rd_data_ff;
   logic [CNT_W-1:0]  count_ff, count_in, count_next;
   logic              ovf_ff, ovf_in, ovf_next;
   logic              busy_ff, busy_in;
   logic              accept;
   logic              has_room;

   assign in_ready   = !busy_ff && !q_full;
   assign accept     = in_valid && in_ready;
   assign has_room   = count_ff < CNT_W'(MAX_LEN);
   assign count_next = has_room ? count_ff + CNT_W'(1) : count_ff;
   assign ovf_next   = ovf_ff | !has_room;
   assign rd_data    = rd_data_ff;

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      busy_in      = busy_ff;
      q_push       = 1'b0;
      q_job.len      = count_next;
      q_job.overflow = ovf_next;
      if (job_done) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         if (in_last) begin
            q_push   = 1'b1;
            count_in = '0;
            ovf_in   = 1'b0;
            busy_in  = 1'b1;
         end else begin
            count_in = count_next;
            ovf_in   = ovf_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         busy_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         busy_ff  <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && has_room) begin
         text_store_ff[count_ff[ADDR_W-1:0]] <= in_ch;
      end
      rd_data_ff <= text_store_ff[rd_addr];
   end

endmodule

/* hw/rtl/pmi_queue.sv */
`timescale 1ns / 1ps
// short job queue between front and back end
// depends on pmi_pkg
module pmi_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pmi_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output pmi_pkg::job_type pop_job,
   output logic             empty
);
   import pmi_pkg::*;

   job_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   fill_ff, fill_in;
   logic                do_push, do_pop;

   assign full    = fill_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty   = fill_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   fill_in = fill_ff + QCNT_W'(1);
         2'b01:   fill_in = fill_ff - QCNT_W'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* hw/rtl/pmi_back.sv */
`timescale 1ns / 1ps
// back end: interval table pass over the stored text, one cell per cycle,
// with two ping-pong row banks and the result register; depends on pmi_pkg
module pmi_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  pmi_pkg::job_type              q_job,
   output logic                          q_pop,
   output logic [pmi_pkg::ADDR_W-1:0]    text_addr,
   input  logic [pmi_pkg::CHAR_W-1:0]    text_data,
   output logic                          job_done,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [pmi_pkg::COST_W-1:0]    out_cost,
   output logic                          out_flag
);
   import pmi_pkg::*;

   back_state_type     state_ff, state_in;
   logic [CNT_W-1:0]   len_ff, len_in;
   logic               ovf_ff, ovf_in;
   logic [ADDR_W-1:0]  i_ff, i_in;
   logic [ADDR_W-1:0]  jc_ff, jc_in;
   logic [CHAR_W-1:0]  ti_ff, ti_in;
   logic               sel_ff, sel_in;
   logic [COST_W-1:0]  cur_jm1_ff, cur_jm1_in;
   logic [COST_W-1:0]  below_jm1_ff, below_jm1_in;
   logic [COST_W-1:0]  ans_ff, ans_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COST_W-1:0]  rsp_cost_ff, rsp_cost_in;
   logic               rsp_flag_ff, rsp_flag_in;

   logic [COST_W-1:0]  bank0_ff [MAX_LEN];
   logic [COST_W-1:0]  bank1_ff [MAX_LEN];
   logic [COST_W-1:0]  b0_rd_ff, b1_rd_ff;

   logic               wr_en;
   logic               out_free;
   logic               row_end;
   logic               first;
   logic [COST_W-1:0]  below_rd, below_eff, diag, drop_right, min_drop, cost;

   assign out_free  = !rsp_valid_ff || out_ready;
   assign row_end   = CNT_W'(jc_ff) == len_ff - CNT_W'(1);
   assign first     = jc_ff == i_ff + ADDR_W'(1);
   assign below_rd  = sel_ff ? b0_rd_ff : b1_rd_ff;
   assign below_eff = first ? '0 : below_rd;
   assign diag      = first ? '0 : below_jm1_ff;
   assign drop_right = first ? '0 : cur_jm1_ff;
   assign min_drop  = (drop_right < below_eff) ? drop_right : below_eff;
   assign cost      = (ti_ff == text_data) ? diag
                    : ((min_drop == COST_CAP) ? COST_CAP : min_drop + COST_W'(1));

   assign out_valid = rsp_valid_ff;
   assign out_cost  = rsp_cost_ff;
   assign out_flag  = rsp_flag_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               state_in = (q_job.len < CNT_W'(2)) ? BK_DONE : BK_FETCH;
            end
         end
         BK_FETCH: state_in = BK_LOAD;
         BK_LOAD:  state_in = BK_CELL;
         BK_CELL: begin
            if (row_end) begin
               state_in = (i_ff == '0) ? BK_DONE : BK_FETCH;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      jc_in        = jc_ff;
      ti_in        = ti_ff;
      sel_in       = sel_ff;
      cur_jm1_in   = cur_jm1_ff;
      below_jm1_in = below_jm1_ff;
      ans_in       = ans_ff;
      rsp_valid_in = rsp_valid_ff && !out_ready;
      rsp_cost_in  = rsp_cost_ff;
      rsp_flag_in  = rsp_flag_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      job_done     = 1'b0;
      text_addr    = jc_ff + ADDR_W'(1);
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               len_in = q_job.len;
               ovf_in = q_job.overflow;
               i_in   = ADDR_W'(q_job.len - CNT_W'(2));
               ans_in = '0;
               sel_in = 1'b0;
            end
         end
         BK_FETCH: begin
            text_addr = i_ff;
         end
         BK_LOAD: begin
            ti_in     = text_data;
            text_addr = i_ff + ADDR_W'(1);
            jc_in     = i_ff + ADDR_W'(1);
         end
         BK_CELL: begin
            wr_en        = 1'b1;
            cur_jm1_in   = cost;
            below_jm1_in = below_eff;
            ans_in       = cost;
            if (row_end) begin
               if (i_ff != '0) begin
                  i_in   = i_ff - ADDR_W'(1);
                  sel_in = !sel_ff;
               end
            end else begin
               jc_in = jc_ff + ADDR_W'(1);
            end
         end
         BK_DONE: begin
            if (out_free) begin
               job_done     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_cost_in  = ans_ff;
               rsp_flag_in  = ovf_ff;
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      ovf_ff       <= ovf_in;
      i_ff         <= i_in;
      jc_ff        <= jc_in;
      ti_ff        <= ti_in;
      sel_ff       <= sel_in;
      cur_jm1_ff   <= cur_jm1_in;
      below_jm1_ff <= below_jm1_in;
      ans_ff       <= ans_in;
      rsp_cost_ff  <= rsp_cost_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en && !sel_ff) begin
         bank0_ff[jc_ff] <= cost;
      end
      if (wr_en && sel_ff) begin
         bank1_ff[jc_ff] <= cost;
      end
      b0_rd_ff <= bank0_ff[text_addr];
      b1_rd_ff <= bank1_ff[text_addr];
   end

endmodule
